@@ sv/albd_pkg.sv @@
// Package: shared types and constants of the ADC ladder button decoder.
`default_nettype none
package albd_pkg;

    localparam int SampleW = 12;
    localparam int RepeatW = 4;
    localparam int HoldW   = 16;
    localparam int CfgIdxW = 3;
    localparam int CfgDatW = 16;

    localparam logic [RepeatW-1:0] RepeatMax = '1;
    localparam logic [HoldW-1:0]   HoldMax   = '1;

    localparam logic [RepeatW-1:0] StableCountRst = RepeatW'(3);
    localparam logic [HoldW-1:0]   LongPressRst   = HoldW'(150);

    typedef enum logic [1:0] {
        LVL_RELEASED = 2'd0,
        LVL_UP       = 2'd1,
        LVL_DOWN     = 2'd2,
        LVL_OK       = 2'd3
    } t_level;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_CLICK = 2'd1,
        EV_LONG  = 2'd2
    } t_event;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_UP_MAX     = 3'd0,
        CFG_DOWN_MIN   = 3'd1,
        CFG_DOWN_MAX   = 3'd2,
        CFG_OK_MIN     = 3'd3,
        CFG_OK_MAX     = 3'd4,
        CFG_STABLE_CNT = 3'd5,
        CFG_LONG_PRESS = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [SampleW-1:0] up_max;
        logic [SampleW-1:0] down_lo;
        logic [SampleW-1:0] down_hi;
        logic [SampleW-1:0] ok_min;
        logic [SampleW-1:0] ok_max;
        logic [RepeatW-1:0] stable_count;
        logic [HoldW-1:0]   long_press_samples;
    } t_cfg;

    typedef struct packed {
        logic [SampleW-1:0] sample;
        logic               read_ok;
    } t_in_item;

    typedef struct packed {
        t_event event_res;
        t_level event_level;
        t_level stable_level;
    } t_out_item;

endpackage
`default_nettype wire

@@ sv/albd_classify.sv @@
// Window classifier: maps one sample to a key level.
`default_nettype none
module albd_classify (
    input  wire  albd_pkg::t_in_item i_item,
    input  wire  albd_pkg::t_cfg     i_cfg,
    output albd_pkg::t_level         o_level
);

    always_comb begin
        if (!i_item.read_ok) begin
            o_level = albd_pkg::LVL_RELEASED;
        end else if (i_item.sample <= i_cfg.up_max) begin
            o_level = albd_pkg::LVL_UP;
        end else if (i_item.sample >= i_cfg.down_lo && i_item.sample <= i_cfg.down_hi) begin
            o_level = albd_pkg::LVL_DOWN;
        end else if (i_item.sample >= i_cfg.ok_min && i_item.sample <= i_cfg.ok_max) begin
            o_level = albd_pkg::LVL_OK;
        end else begin
            o_level = albd_pkg::LVL_RELEASED;
        end
    end

endmodule
`default_nettype wire

@@ sv/albd_track.sv @@
// Debounce and press tracker: state registers and click / long press events.
`default_nettype none
module albd_track (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_adv,
    input  wire  albd_pkg::t_level    i_level,
    input  wire  albd_pkg::t_cfg      i_cfg,
    output albd_pkg::t_out_item       o_res
);

    albd_pkg::t_level r_conf, n_conf;
    albd_pkg::t_level r_cand, n_cand;
    albd_pkg::t_level r_held, n_held;
    logic [albd_pkg::RepeatW-1:0] r_rep, n_rep;
    logic [albd_pkg::HoldW-1:0]   r_hold, n_hold;
    logic r_key_down, n_key_down;
    logic r_long_done, n_long_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conf      <= albd_pkg::LVL_RELEASED;
            r_cand      <= albd_pkg::LVL_RELEASED;
            r_held      <= albd_pkg::LVL_RELEASED;
            r_rep       <= '0;
            r_hold      <= '0;
            r_key_down  <= 1'b0;
            r_long_done <= 1'b0;
        end else if (i_adv) begin
            r_conf      <= n_conf;
            r_cand      <= n_cand;
            r_held      <= n_held;
            r_rep       <= n_rep;
            r_hold      <= n_hold;
            r_key_down  <= n_key_down;
            r_long_done <= n_long_done;
        end
    end

    always_comb begin
        n_conf      = r_conf;
        n_cand      = r_cand;
        n_held      = r_held;
        n_rep       = r_rep;
        n_hold      = r_hold;
        n_key_down  = r_key_down;
        n_long_done = r_long_done;
        o_res.event_res   = albd_pkg::EV_NONE;
        o_res.event_level = albd_pkg::LVL_RELEASED;

        if (i_level == r_cand) begin
            if (r_rep != albd_pkg::RepeatMax) begin
                n_rep = r_rep + 1'b1;
            end
            if (n_rep >= i_cfg.stable_count && i_level != r_conf) begin
                n_conf = i_level;
                if (i_level == albd_pkg::LVL_RELEASED) begin
                    if (r_key_down) begin
                        n_key_down = 1'b0;
                        if (!r_long_done) begin
                            o_res.event_res   = albd_pkg::EV_CLICK;
                            o_res.event_level = r_held;
                        end
                        n_long_done = 1'b0;
                    end
                end else begin
                    n_key_down  = 1'b1;
                    n_held      = i_level;
                    n_long_done = 1'b0;
                    n_hold      = '0;
                end
            end
        end else begin
            n_cand = i_level;
            n_rep  = albd_pkg::RepeatW'(1);
        end

        if (n_key_down && !n_long_done && n_hold >= i_cfg.long_press_samples) begin
            n_long_done       = 1'b1;
            o_res.event_res   = albd_pkg::EV_LONG;
            o_res.event_level = n_held;
        end
        if (n_key_down && n_hold != albd_pkg::HoldMax) begin
            n_hold = n_hold + 1'b1;
        end

        o_res.stable_level = n_conf;
    end

endmodule
`default_nettype wire

@@ sv/adc_ladder_button_decoder_top.sv @@
// Top level: configuration registers, input and result registers, decoder core.
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------
//  in      | i_valid / o_ready          | i_item (sample, read_ok)
//  out     | o_valid / i_ready          | o_item (event_res, event_level,
//          |                            |         stable_level)
//  cfg     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item per cycle unless the output stalls; an item in the input register
// passes through classification and tracking into the result register once that
// register is empty or draining. Synchronous reset clears the valid flags, the
// tracker state and sets the configuration registers to their documented values;
// the input and result data registers are not reset. A stalled result holds the
// result register; the input register keeps taking items while the result drains.
`default_nettype none
module adc_ladder_button_decoder_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire  albd_pkg::t_in_item     i_item,
    output logic                         o_valid,
    input  wire                          i_ready,
    output albd_pkg::t_out_item          o_item,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [albd_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire  [albd_pkg::CfgDatW-1:0] i_cfg_data
);

    albd_pkg::t_cfg      r_cfg;
    albd_pkg::t_in_item  r_in;
    logic                r_in_valid;
    albd_pkg::t_out_item r_out;
    logic                r_out_valid;
    albd_pkg::t_level    level;
    albd_pkg::t_out_item res;
    logic                adv;

    assign adv         = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready     = i_rst_n && (!r_in_valid || adv);
    assign o_cfg_ready = i_rst_n;
    assign o_valid     = r_out_valid;
    assign o_item      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.up_max             <= '0;
            r_cfg.down_lo            <= '0;
            r_cfg.down_hi            <= '0;
            r_cfg.ok_min             <= '0;
            r_cfg.ok_max             <= '0;
            r_cfg.stable_count       <= albd_pkg::StableCountRst;
            r_cfg.long_press_samples <= albd_pkg::LongPressRst;
        end else if (i_cfg_valid) begin
            case (albd_pkg::t_cfg_idx'(i_cfg_index))
                albd_pkg::CFG_UP_MAX:     r_cfg.up_max  <= i_cfg_data[albd_pkg::SampleW-1:0];
                albd_pkg::CFG_DOWN_MIN:   r_cfg.down_lo <= i_cfg_data[albd_pkg::SampleW-1:0];
                albd_pkg::CFG_DOWN_MAX:   r_cfg.down_hi <= i_cfg_data[albd_pkg::SampleW-1:0];
                albd_pkg::CFG_OK_MIN:     r_cfg.ok_min  <= i_cfg_data[albd_pkg::SampleW-1:0];
                albd_pkg::CFG_OK_MAX:     r_cfg.ok_max  <= i_cfg_data[albd_pkg::SampleW-1:0];
                albd_pkg::CFG_STABLE_CNT: begin
                    r_cfg.stable_count <= i_cfg_data[albd_pkg::RepeatW-1:0];
                end
                albd_pkg::CFG_LONG_PRESS: begin
                    r_cfg.long_press_samples <= i_cfg_data[albd_pkg::HoldW-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_item;
        end
        if (adv) begin
            r_out <= res;
        end
    end

    albd_classify u_classify (
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_level (level)
    );

    albd_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_level (level),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    a_event_has_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.event_res != albd_pkg::EV_NONE)
        |-> (o_item.event_level != albd_pkg::LVL_RELEASED))
        else $error("event without a key");

    a_quiet_no_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.event_res == albd_pkg::EV_NONE)
        |-> (o_item.event_level == albd_pkg::LVL_RELEASED))
        else $error("key level without an event");

    a_click_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.event_res == albd_pkg::EV_CLICK)
        |-> (o_item.stable_level == albd_pkg::LVL_RELEASED))
        else $error("click while a key is still down");

    a_long_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.event_res == albd_pkg::EV_LONG)
        |-> (o_item.stable_level != albd_pkg::LVL_RELEASED))
        else $error("long press while released");

endmodule
`default_nettype wire
